[rtl/mlt_pkg.sv]
package mlt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ADDR_W      = 48;
    localparam int PORT_W      = 4;
    localparam logic [ADDR_W-1:0] BCAST_ADDR = {ADDR_W{1'b1}};

    typedef enum logic [1:0] {
        OP_LEARN  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        EV_KNOWN   = 3'd0,
        EV_MOVED   = 3'd1,
        EV_LEARNED = 3'd2,
        EV_FULL    = 3'd3,
        EV_HIT     = 3'd4,
        EV_MISS    = 3'd5,
        EV_BCAST   = 3'd6,
        EV_FLUSHED = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_LAST_RD,
        S_LAST_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic [IDX_W-1:0]  wr_addr;
        logic              wr_mac_en;
        logic              wr_port_en;
        logic [ADDR_W-1:0] wr_mac;
        logic [PORT_W-1:0] wr_port;
    } t_ram_ctl;

    typedef struct packed {
        t_event            event_res;
        logic [PORT_W-1:0] port_out;
        logic              flood;
        logic [PORT_W-1:0] prev_port;
        logic [CNT_W-1:0]  entry_count;
        logic [CNT_W-1:0]  removed;
    } t_result;

endpackage

[rtl/mlt_ram.sv]
module mlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/mlt_seq.sv]
module mlt_seq
    import mlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_mac_addr,
    input  logic [PORT_W-1:0] i_port_in,
    input  logic [ADDR_W-1:0] i_rd_mac,
    input  logic [PORT_W-1:0] i_rd_port,
    output t_ram_ctl          o_ram,
    output logic              o_done,
    input  logic              i_taken,
    output t_result           o_result
);

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [ADDR_W-1:0] r_mac, n_mac;
    logic [PORT_W-1:0] r_port, n_port;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_removed, n_removed;
    t_event            r_ev, n_ev;
    logic [PORT_W-1:0] r_pout, n_pout;
    logic              r_flood, n_flood;
    logic [PORT_W-1:0] r_prev, n_prev;
    logic [CNT_W-1:0]  last_idx;

    assign last_idx = r_count - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op      <= n_op;
        r_mac     <= n_mac;
        r_port    <= n_port;
        r_idx     <= n_idx;
        r_removed <= n_removed;
        r_ev      <= n_ev;
        r_pout    <= n_pout;
        r_flood   <= n_flood;
        r_prev    <= n_prev;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_mac     = r_mac;
        n_port    = r_port;
        n_idx     = r_idx;
        n_count   = r_count;
        n_removed = r_removed;
        n_ev      = r_ev;
        n_pout    = r_pout;
        n_flood   = r_flood;
        n_prev    = r_prev;
        o_ram.rd_addr    = r_idx[IDX_W-1:0];
        o_ram.wr_addr    = r_idx[IDX_W-1:0];
        o_ram.wr_mac_en  = 1'b0;
        o_ram.wr_port_en = 1'b0;
        o_ram.wr_mac     = r_mac;
        o_ram.wr_port    = r_port;
        o_in_stall       = (r_state != S_IDLE);
        o_done           = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = t_op'(i_op);
                    n_mac     = i_mac_addr;
                    n_port    = i_port_in;
                    n_idx     = '0;
                    n_removed = '0;
                    n_pout    = '0;
                    n_flood   = 1'b0;
                    n_prev    = '0;
                    if (t_op'(i_op) == OP_LOOKUP && i_mac_addr == BCAST_ADDR) begin
                        n_ev    = EV_BCAST;
                        n_flood = 1'b1;
                        n_state = S_DONE;
                    end else if (t_op'(i_op) != OP_NONE) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_idx >= r_count) begin
                    n_state = S_DONE;
                    case (r_op)
                        OP_LEARN: begin
                            if (r_count < CNT_W'(TABLE_DEPTH)) begin
                                o_ram.wr_addr    = r_count[IDX_W-1:0];
                                o_ram.wr_mac_en  = 1'b1;
                                o_ram.wr_port_en = 1'b1;
                                n_count          = r_count + CNT_W'(1);
                                n_ev             = EV_LEARNED;
                            end else begin
                                n_ev = EV_FULL;
                            end
                        end
                        OP_LOOKUP: begin
                            n_ev    = EV_MISS;
                            n_flood = 1'b1;
                        end
                        default: begin
                            n_ev = EV_FLUSHED;
                        end
                    endcase
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_op == OP_FLUSH) begin
                    if (i_rd_port == r_port) begin
                        n_state = S_LAST_RD;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_RD;
                    end
                end else if (i_rd_mac == r_mac) begin
                    n_state = S_DONE;
                    if (r_op == OP_LOOKUP) begin
                        n_ev   = EV_HIT;
                        n_pout = i_rd_port;
                    end else if (i_rd_port != r_port) begin
                        o_ram.wr_port_en = 1'b1;
                        n_ev             = EV_MOVED;
                        n_prev           = i_rd_port;
                    end else begin
                        n_ev = EV_KNOWN;
                    end
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_RD;
                end
            end
            S_LAST_RD: begin
                o_ram.rd_addr = last_idx[IDX_W-1:0];
                n_state       = S_LAST_WR;
            end
            S_LAST_WR: begin
                o_ram.wr_mac_en  = 1'b1;
                o_ram.wr_port_en = 1'b1;
                o_ram.wr_mac     = i_rd_mac;
                o_ram.wr_port    = i_rd_port;
                n_count          = last_idx;
                n_removed        = r_removed + CNT_W'(1);
                n_state          = S_RD;
            end
            S_DONE: begin
                o_done = 1'b1;
                if (i_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result.event_res   = r_ev;
    assign o_result.port_out    = r_pout;
    assign o_result.flood       = r_flood;
    assign o_result.prev_port   = r_prev;
    assign o_result.entry_count = r_count;
    assign o_result.removed     = r_removed;

endmodule

[rtl/mac_learning_table_top.sv]
// Switch address table, 1024 entries of 48-bit address and 4-bit port, no aging.
// One beat at a time: learn and lookup scan the filled entries linearly, each
// entry checked with a registered memory read, then a compare; a broadcast
// lookup skips the scan. A flush scans every filled entry and removes each match
// by copying the last entry into its slot (read, then write) and rechecking
// that slot. The input is stalled while an item is in work; a finished result
// sits in an output register so the next beat can be taken while it waits. No
// clearing pass after reset: the fill count bounds all reads.
module mac_learning_table_top
    import mlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_mac_addr,
    input  logic [PORT_W-1:0] i_port_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_event_res,
    output logic [PORT_W-1:0] o_port_out,
    output logic              o_flood,
    output logic [PORT_W-1:0] o_prev_port,
    output logic [CNT_W-1:0]  o_entry_count,
    output logic [CNT_W-1:0]  o_removed
);

    t_ram_ctl          ram;
    t_result           result;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic              done;
    logic              taken;
    logic [ADDR_W-1:0] rd_mac;
    logic [PORT_W-1:0] rd_port;

    mlt_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_addr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram.wr_mac_en),
        .i_wr_addr (ram.wr_addr),
        .i_wr_data (ram.wr_mac),
        .i_rd_addr (ram.rd_addr),
        .o_rd_data (rd_mac)
    );

    mlt_ram #(.WIDTH(PORT_W), .DEPTH(TABLE_DEPTH)) u_port_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram.wr_port_en),
        .i_wr_addr (ram.wr_addr),
        .i_wr_data (ram.wr_port),
        .i_rd_addr (ram.rd_addr),
        .o_rd_data (rd_port)
    );

    mlt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_mac_addr (i_mac_addr),
        .i_port_in  (i_port_in),
        .i_rd_mac   (rd_mac),
        .i_rd_port  (rd_port),
        .o_ram      (ram),
        .o_done     (done),
        .i_taken    (taken),
        .o_result   (result)
    );

    assign taken = done && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (taken) begin
            n_out       = result;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_port_out    = r_out.port_out;
    assign o_flood       = r_out.flood;
    assign o_prev_port   = r_out.prev_port;
    assign o_entry_count = r_out.entry_count;
    assign o_removed     = r_out.removed;

endmodule

[rtl/mlt_checker.sv]
module mlt_checker
    import mlt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [1:0]        i_op,
    input logic [ADDR_W-1:0] i_mac_addr,
    input logic [PORT_W-1:0] i_port_in,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [2:0]        o_event_res,
    input logic [PORT_W-1:0] o_port_out,
    input logic              o_flood,
    input logic [PORT_W-1:0] o_prev_port,
    input logic [CNT_W-1:0]  o_entry_count,
    input logic [CNT_W-1:0]  o_removed
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_event_res)
            && $stable(o_entry_count))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_flood: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_flood == (o_event_res == EV_MISS || o_event_res == EV_BCAST))
        else $error("flood does not match event");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_res == EV_FLUSHED || o_removed == '0)
            && (o_event_res == EV_HIT || o_port_out == '0)
            && (o_event_res == EV_MOVED || o_prev_port == '0))
        else $error("field set outside its event");

endmodule

bind mac_learning_table_top mlt_checker u_mlt_checker (.*);
